/* hdl/fdss_pkg.sv */
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and segment table for the four-digit scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package fdss_pkg;

  // request kind carried on the input tuser bit
  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] new_value;
  } item_t;

  // four decimal digits, digit p in element p
  typedef logic [3:0][3:0] digits_t;

  localparam logic [13:0] MAX_SHOWN      = 14'd9999;
  localparam logic [3:0]  ALL_DIGITS_OFF = 4'hF;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'h77;
      4'd1: seg = 8'h14;
      4'd2: seg = 8'h5b;
      4'd3: seg = 8'h5e;
      4'd4: seg = 8'h3c;
      4'd5: seg = 8'h6e;
      4'd6: seg = 8'h6f;
      4'd7: seg = 8'h74;
      4'd8: seg = 8'h7f;
      4'd9: seg = 8'h7e;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

/* hdl/fdss_bcd.sv */
// ----------------------------------------------------------------------------
// fdss_bcd
// Splits a value of at most 9999 into four decimal digits with three
// compare-and-subtract levels.
// ----------------------------------------------------------------------------
`default_nettype none

module fdss_bcd (
  input  wire logic [13:0]     value_i,
  output fdss_pkg::digits_t    digits_o
);

  logic [3:0] d3;
  logic [3:0] d2;
  logic [3:0] d1;
  logic [9:0] rem3;
  logic [6:0] rem2;
  logic [3:0] rem1;

  // thousands
  always_comb begin
    d3   = 4'd0;
    rem3 = value_i[9:0];
    for (int k = 1; k <= 9; k++) begin
      if (value_i >= 14'(k * 1000)) begin
        d3   = 4'(k);
        rem3 = 10'(value_i - 14'(k * 1000));
      end
    end
  end

  // hundreds
  always_comb begin
    d2   = 4'd0;
    rem2 = rem3[6:0];
    for (int k = 1; k <= 9; k++) begin
      if (rem3 >= 10'(k * 100)) begin
        d2   = 4'(k);
        rem2 = 7'(rem3 - 10'(k * 100));
      end
    end
  end

  // tens and units
  always_comb begin
    d1   = 4'd0;
    rem1 = rem2[3:0];
    for (int k = 1; k <= 9; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        d1   = 4'(k);
        rem1 = 4'(rem2 - 7'(k * 10));
      end
    end
  end

  assign digits_o = {d3, d2, d1, rem1};

endmodule

`default_nettype wire

/* hdl/fdss_scan.sv */
// ----------------------------------------------------------------------------
// fdss_scan
// Display state and result register: stores the value and its digits on a
// write, drives one digit per tick with leading-zero blanking.
// ----------------------------------------------------------------------------
`default_nettype none

module fdss_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire fdss_pkg::item_t item_i,
  output logic [7:0]           segment_lines_o,
  output logic [3:0]           digit_enables_n_o,
  output logic [13:0]          shown_value_o
);

  logic [13:0]       value_q,  value_d;
  fdss_pkg::digits_t digits_q, digits_d;
  logic [1:0]        pos_q,    pos_d;
  logic [7:0]        seg_q,    seg_d;
  logic [3:0]        en_q,     en_d;

  logic [13:0]       sat_value;
  fdss_pkg::digits_t wr_digits;
  logic              show;

  assign sat_value = (item_i.new_value > 16'(fdss_pkg::MAX_SHOWN)) ?
                     fdss_pkg::MAX_SHOWN : item_i.new_value[13:0];

  fdss_bcd u_bcd (
    .value_i  (sat_value),
    .digits_o (wr_digits)
  );

  // leading-zero blanking from the stored digits
  always_comb begin
    case (pos_q)
      2'd0:    show = 1'b1;
      2'd1:    show = |{digits_q[3], digits_q[2], digits_q[1]};
      2'd2:    show = |{digits_q[3], digits_q[2]};
      2'd3:    show = |digits_q[3];
      default: show = 1'b1;
    endcase
  end

  always_comb begin
    value_d  = value_q;
    digits_d = digits_q;
    pos_d    = pos_q;
    seg_d    = seg_q;
    en_d     = en_q;
    if (advance_i) begin
      if (item_i.opcode == fdss_pkg::OP_WRITE) begin
        value_d  = sat_value;
        digits_d = wr_digits;
      end else begin
        en_d = fdss_pkg::ALL_DIGITS_OFF;
        if (show) begin
          seg_d = fdss_pkg::seg_of(digits_q[pos_q]);
          en_d  = fdss_pkg::ALL_DIGITS_OFF & ~(4'b0001 << pos_q);
        end
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q  <= '0;
      digits_q <= '0;
      pos_q    <= 2'd0;
      seg_q    <= 8'h00;
      en_q     <= fdss_pkg::ALL_DIGITS_OFF;
    end else begin
      value_q  <= value_d;
      digits_q <= digits_d;
      pos_q    <= pos_d;
      seg_q    <= seg_d;
      en_q     <= en_d;
    end
  end

  assign segment_lines_o   = seg_q;
  assign digit_enables_n_o = en_q;
  assign shown_value_o     = value_q;

`ifndef NO_ASSERTIONS
  a_one_digit_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(~en_q))
    else $error("more than one digit enabled");

  a_write_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.opcode == fdss_pkg::OP_WRITE |=> value_q <= fdss_pkg::MAX_SHOWN)
    else $error("stored value above 9999");

  a_write_keeps_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.opcode == fdss_pkg::OP_WRITE |=>
      $stable(seg_q) && $stable(en_q) && $stable(pos_q))
    else $error("write disturbed the scan latches");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.opcode == fdss_pkg::OP_TICK |=> pos_q == $past(pos_q) + 2'd1)
    else $error("scan position did not advance");

  a_pos0_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.opcode == fdss_pkg::OP_TICK && pos_q == 2'd0 |=>
      en_q == 4'b1110)
    else $error("position zero not enabled");
`endif

endmodule

`default_nettype wire

/* hdl/four_digit_seven_segment_scanner.sv */
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner
// Scans a four-digit multiplexed seven-segment display, one digit per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser[0] selects the request kind (0 = scan tick,
//   1 = write), tdata[15:0] carries the value for a write (saturates to 9999).
//   Output stream: one result per request with the segment latch, the
//   active-low digit enables and the stored value after that request.
//   A request accepted into the input register passes through the compute
//   stage into the display state register, whose outputs form its result.
//   Throughput: one request per cycle while the receiver takes results, set
//   by the single compute stage between the input register and the display state register.
//   When the receiver stalls, the result holds and the input register
//   still takes one more request; tready drops only when both are full.
//   Reset: value 0, scan position 0, segments 0, all digits off, no result
//   pending.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_seven_segment_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // new_value[15:0]
  input  wire logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // segment_lines[7:0], digit_enables_n[11:8],
                                           // shown_value[25:12], zero[31:26]
);

  logic            in_valid_q,  in_valid_d;
  fdss_pkg::item_t in_item_q;
  logic            out_valid_q, out_valid_d;
  logic            advance;
  logic            s_accept;

  logic [7:0]      segment_lines;
  logic [3:0]      digit_enables_n;
  logic [13:0]     shown_value;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.opcode    <= fdss_pkg::op_e'(s_axis_tuser[0]);
      in_item_q.new_value <= s_axis_tdata;
    end
  end

  fdss_scan u_scan (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .item_i            (in_item_q),
    .segment_lines_o   (segment_lines),
    .digit_enables_n_o (digit_enables_n),
    .shown_value_o     (shown_value)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, shown_value, digit_enables_n, segment_lines};

endmodule

`default_nettype wire

/* bench/four_digit_seven_segment_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner_tb
// Streams scan ticks and value writes into the scanner and predicts the
// segment latch, the active-low enables and the stored value of every result.
// Runs a directed sweep over saturation and leading-zero blanking, then
// random traffic with random gaps and stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

module four_digit_seven_segment_scanner_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 60;

  // predicted display state, one expectation per request
  class display_scoreboard;
    typedef struct {
      logic [7:0]  segments;
      logic [3:0]  enables_n;
      logic [13:0] value;
    } display_result_t;

    logic [7:0]  digit_patterns [0:9] = '{8'h77, 8'h14, 8'h5b, 8'h5e, 8'h3c,
                                          8'h6e, 8'h6f, 8'h74, 8'h7f, 8'h7e};
    int unsigned place_weight [0:3] = '{1, 10, 100, 1000};

    logic [13:0]     stored_value;
    logic [1:0]      scan_pos;
    logic [7:0]      segment_state;
    logic [3:0]      enable_state;
    display_result_t expected_results [$];
    int              failures;

    function new();
      stored_value  = '0;
      scan_pos      = '0;
      segment_state = '0;
      enable_state  = fdss_pkg::ALL_DIGITS_OFF;
      failures      = 0;
    endfunction

    function void note_request(fdss_pkg::op_e op, logic [15:0] data);
      display_result_t r;
      int unsigned weight;
      if (op == fdss_pkg::OP_WRITE) begin
        stored_value = (data > fdss_pkg::MAX_SHOWN) ? fdss_pkg::MAX_SHOWN : data[13:0];
      end else begin
        weight       = place_weight[scan_pos];
        enable_state = fdss_pkg::ALL_DIGITS_OFF;
        // leading zeros stay dark, digit 0 is always lit
        if (scan_pos == 2'd0 || stored_value >= weight) begin
          segment_state          = digit_patterns[(stored_value / weight) % 10];
          enable_state[scan_pos] = 1'b0;
        end
        scan_pos = scan_pos + 2'd1;
      end
      r.segments  = segment_state;
      r.enables_n = enable_state;
      r.value     = stored_value;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] tdata);
      display_result_t r;
      if (expected_results.size() == 0) begin
        if (failures < 10) $display("unexpected result %h", tdata);
        failures++;
        return;
      end
      r = expected_results.pop_front();
      if (tdata[7:0] !== r.segments || tdata[11:8] !== r.enables_n ||
          tdata[25:12] !== r.value) begin
        if (failures < 10)
          $display("mismatch: seg exp %h got %h, en_n exp %h got %h, value exp %0d got %0d",
                   r.segments, tdata[7:0], r.enables_n, tdata[11:8], r.value,
                   tdata[25:12]);
        failures++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit passed();
      return failures == 0 && expected_results.size() == 0;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  display_scoreboard sb = new();
  int  accepted_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  four_digit_seven_segment_scanner DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // no idling on either side during this stretch of requests
  function automatic bit steady_stretch();
    return accepted_count >= 250 && accepted_count < 400;
  endfunction

  function automatic bit take_gap();
    return !steady_stretch() && $urandom_range(0, 99) < 9;
  endfunction

  task automatic send_request(fdss_pkg::op_e op, logic [15:0] data);
    @(negedge clk_i);
    while (take_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, data);
    accepted_count++;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 9));
      2:       return 16'($urandom_range(10, 99));
      3:       return 16'($urandom_range(100, 999));
      4:       return 16'($urandom_range(1000, 9999));
      5:       return 16'($urandom_range(9990, 10010));
      default: return 16'($urandom_range(0, 9999));
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off to back up the input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && accepted_count >= 500) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_gap();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    fdss_pkg::op_e dir_ops [24] = '{
      fdss_pkg::OP_WRITE, fdss_pkg::OP_TICK, fdss_pkg::OP_TICK, fdss_pkg::OP_TICK,
      fdss_pkg::OP_TICK, fdss_pkg::OP_WRITE, fdss_pkg::OP_TICK, fdss_pkg::OP_TICK,
      fdss_pkg::OP_TICK, fdss_pkg::OP_TICK, fdss_pkg::OP_WRITE, fdss_pkg::OP_WRITE,
      fdss_pkg::OP_TICK, fdss_pkg::OP_TICK, fdss_pkg::OP_WRITE, fdss_pkg::OP_TICK,
      fdss_pkg::OP_WRITE, fdss_pkg::OP_TICK, fdss_pkg::OP_WRITE, fdss_pkg::OP_TICK,
      fdss_pkg::OP_TICK, fdss_pkg::OP_TICK, fdss_pkg::OP_WRITE, fdss_pkg::OP_TICK};
    logic [15:0] dir_vals [24] = '{16'd0, 16'hffff, 16'h0000, 16'h5555, 16'haaaa,
                                   16'd65535, 16'h0, 16'h1, 16'h8000, 16'h7fff,
                                   16'd10000, 16'd9, 16'h0, 16'h0,
                                   16'd10, 16'h0, 16'd999, 16'h0,
                                   16'd100, 16'h0, 16'h0, 16'h0,
                                   16'd1000, 16'h0};
    fdss_pkg::op_e op;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero shows one digit, saturation, each blanking threshold at its position
    foreach (dir_ops[i]) send_request(dir_ops[i], dir_vals[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      op = ($urandom_range(0, 99) < 20) ? fdss_pkg::OP_WRITE : fdss_pkg::OP_TICK;
      send_request(op, (op == fdss_pkg::OP_WRITE) ? pick_value() : 16'($urandom));
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.passed()) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
